@@ rtl/core/rgbhsv_pkg.sv @@
// rgb to hsv converter: shared types and constants
// used by every module of the converter, no dependencies
`default_nettype none

package rgbhsv_pkg;

    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned QUO_W     = 16;
    localparam int unsigned DIVD_W    = CHAN_W + QUO_W;
    localparam int unsigned HUE_W     = 15;
    localparam int unsigned SAT_W     = 16;
    localparam int unsigned HUE_Q_W   = 12;
    localparam int unsigned NUM_CELLS = QUO_W;
    localparam int unsigned IN_W      = 32;
    localparam int unsigned OUT_W     = 40;

    localparam logic [HUE_W-1:0] HUE_RED_BASE   = 15'd0;
    localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 15'd7680;
    localparam logic [HUE_W-1:0] HUE_BLUE_BASE  = 15'd15360;
    localparam logic [HUE_W-1:0] HUE_FULL_TURN  = 15'd23040;

    // one long-division lane: bits holds unconsumed dividend bits above,
    // quotient bits shifted in from below
    typedef struct packed {
        logic [CHAN_W-1:0] divisor;
        logic [CHAN_W-1:0] rem;
        logic [QUO_W-1:0]  bits;
    } rgbhsv_lane_t;

    typedef struct packed {
        logic              grey;
        logic              wrap_neg;
        logic [HUE_W-1:0]  base;
        logic [CHAN_W-1:0] value;
    } rgbhsv_side_t;

    typedef struct packed {
        rgbhsv_side_t side;
        rgbhsv_lane_t sat;
        rgbhsv_lane_t hue;
    } rgbhsv_stage_t;

endpackage

`default_nettype wire

@@ rtl/core/rgbhsv_front.sv @@
// front stage: max, min, sector and the two dividends for the cell chain
// depends on rgbhsv_pkg
`default_nettype none

module rgbhsv_front
    import rgbhsv_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                valid_in,
    input  wire logic [IN_W-1:0]     pixel_argb,
    output logic                     valid_out,
    output rgbhsv_stage_t            stage_out
);

    logic [CHAN_W-1:0] r, g, b, mx, mn, delta, pos, neg, diff;
    logic              is_neg;
    logic [HUE_W-1:0]  base;
    logic [DIVD_W-1:0] sat_num, hue_num;
    rgbhsv_stage_t     stage_next, stage_reg;
    logic              valid_reg;

    always_comb begin
        r = pixel_argb[23:16];
        g = pixel_argb[15:8];
        b = pixel_argb[7:0];
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;

        // red wins ties, then green
        if (r >= mx) begin
            pos = g; neg = b; base = HUE_RED_BASE;
        end else if (g >= mx) begin
            pos = b; neg = r; base = HUE_GREEN_BASE;
        end else begin
            pos = r; neg = g; base = HUE_BLUE_BASE;
        end
        is_neg = (pos < neg);
        diff   = is_neg ? (neg - pos) : (pos - neg);
        if (is_neg && (base == HUE_RED_BASE)) base = HUE_FULL_TURN;

        // 65280*delta and 3840*diff by shifts
        sat_num = ({delta, 16'd0}) - ({8'd0, delta, 8'd0});
        hue_num = ({4'd0, diff, 12'd0}) - ({8'd0, diff, 8'd0});

        stage_next.side.grey     = (delta == '0);
        stage_next.side.wrap_neg = is_neg;
        stage_next.side.base     = base;
        stage_next.side.value    = mx;
        stage_next.sat.divisor   = mx;
        stage_next.sat.rem       = sat_num[DIVD_W-1:QUO_W];
        stage_next.sat.bits      = sat_num[QUO_W-1:0];
        stage_next.hue.divisor   = delta;
        stage_next.hue.rem       = hue_num[DIVD_W-1:QUO_W];
        stage_next.hue.bits      = hue_num[QUO_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign valid_out = valid_reg;
    assign stage_out = stage_reg;

endmodule

`default_nettype wire

@@ rtl/core/rgbhsv_cell.sv @@
// one cell of the division chain: a restoring step on both lanes
// depends on rgbhsv_pkg
`default_nettype none

module rgbhsv_cell
    import rgbhsv_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          valid_in,
    input  wire rgbhsv_stage_t stage_in,
    output logic               valid_out,
    output rgbhsv_stage_t      stage_out
);

    function automatic rgbhsv_lane_t lane_step(input rgbhsv_lane_t lane);
        logic [CHAN_W+1:0] trial;
        logic [CHAN_W:0]   shifted;
        rgbhsv_lane_t      res;
        shifted = {lane.rem, lane.bits[QUO_W-1]};
        trial   = {1'b0, shifted} - {2'b00, lane.divisor};
        res.divisor = lane.divisor;
        if (!trial[CHAN_W+1]) begin
            res.rem  = trial[CHAN_W-1:0];
            res.bits = {lane.bits[QUO_W-2:0], 1'b1};
        end else begin
            // remainder below divisor, so the top bit is clear
            res.rem  = shifted[CHAN_W-1:0];
            res.bits = {lane.bits[QUO_W-2:0], 1'b0};
        end
        return res;
    endfunction

    rgbhsv_stage_t stage_next, stage_reg;
    logic          valid_reg;

    always_comb begin
        stage_next.side = stage_in.side;
        stage_next.sat  = lane_step(stage_in.sat);
        stage_next.hue  = lane_step(stage_in.hue);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign valid_out = valid_reg;
    assign stage_out = stage_reg;

endmodule

`default_nettype wire

@@ rtl/core/rgbhsv_back.sv @@
// back stage: hue from sector base and quotient, output register
// depends on rgbhsv_pkg
`default_nettype none

module rgbhsv_back
    import rgbhsv_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          valid_in,
    input  wire rgbhsv_stage_t stage_in,
    output logic               valid_out,
    output logic [HUE_W-1:0]   hue_fixed,
    output logic [SAT_W-1:0]   saturation_fixed,
    output logic [CHAN_W-1:0]  value_level
);

    logic [HUE_W-1:0]  q, hue_next, hue_reg;
    logic [SAT_W-1:0]  sat_next, sat_reg;
    logic [CHAN_W-1:0] val_reg;
    logic              valid_reg;

    always_comb begin
        q = {{(HUE_W-HUE_Q_W){1'b0}}, stage_in.hue.bits[HUE_Q_W-1:0]};
        // negative offset truncates toward minus: round the quotient up
        if (stage_in.side.wrap_neg) begin
            hue_next = stage_in.side.base - q
                     - {{(HUE_W-1){1'b0}}, (stage_in.hue.rem != '0)};
        end else begin
            hue_next = stage_in.side.base + q;
        end
        sat_next = stage_in.sat.bits;
        if (stage_in.side.grey) begin
            hue_next = '0;
            sat_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= stage_in.side.value;
        end
    end

    assign valid_out        = valid_reg;
    assign hue_fixed        = hue_reg;
    assign saturation_fixed = sat_reg;
    assign value_level      = val_reg;

endmodule

`default_nettype wire

@@ rtl/core/rgb_to_hsv_converter.sv @@
// rgb to hsv converter top level: front stage, chain of division cells, back stage
// depends on rgbhsv_pkg, rgbhsv_front, rgbhsv_cell, rgbhsv_back
//
//  channel   dir  tdata fields (low bit up)                       tuser  tlast
//  s_axis    in   pixel_argb[31:0]                                none   none
//  m_axis    out  hue_fixed[14:0] saturation_fixed[30:15]
//                 value_level[38:31], bit 39 zero                 none   none
//
// one request accepted every cycle while the output is not stalled; a result passes
// the front stage, 16 division cells at one quotient bit each, and the output register
// all stages advance together; a stalled output holds the whole chain and
// s_axis_tready falls with it
// synchronous active-low reset clears the valid bits only
`default_nettype none

module rgb_to_hsv_converter
    import rgbhsv_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [IN_W-1:0]   s_axis_tdata,   // pixel_argb
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [OUT_W-1:0]       m_axis_tdata    // hue_fixed, saturation_fixed, value_level
);

    logic                en;
    logic                valid_chain [NUM_CELLS+1];
    rgbhsv_stage_t       stage_chain [NUM_CELLS+1];
    logic [HUE_W-1:0]    hue_fixed;
    logic [SAT_W-1:0]    saturation_fixed;
    logic [CHAN_W-1:0]   value_level;

    assign en            = m_axis_tready | ~m_axis_tvalid;
    assign s_axis_tready = en;

    rgbhsv_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .valid_in   (s_axis_tvalid),
        .pixel_argb (s_axis_tdata),
        .valid_out  (valid_chain[0]),
        .stage_out  (stage_chain[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        rgbhsv_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (valid_chain[i]),
            .stage_in  (stage_chain[i]),
            .valid_out (valid_chain[i+1]),
            .stage_out (stage_chain[i+1])
        );
    end

    rgbhsv_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .en               (en),
        .valid_in         (valid_chain[NUM_CELLS]),
        .stage_in         (stage_chain[NUM_CELLS]),
        .valid_out        (m_axis_tvalid),
        .hue_fixed        (hue_fixed),
        .saturation_fixed (saturation_fixed),
        .value_level      (value_level)
    );

    assign m_axis_tdata = {{(OUT_W-HUE_W-SAT_W-CHAN_W){1'b0}},
                           value_level, saturation_fixed, hue_fixed};

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// self-checking bench for rgb_to_hsv_converter: directed pixels, then random ones
// expected hsv worked out in-bench; random idling on s_axis and backpressure on m_axis
// depends on rgbhsv_pkg and rgb_to_hsv_converter
`timescale 1ns / 1ps

module tb_top
    import rgbhsv_pkg::*;
;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [SAT_W-1:0]  sat;
        logic [CHAN_W-1:0] value;
    } hsv_t;

    typedef struct {
        logic [IN_W-1:0] pixel;
        bit              typed;
        hsv_t            result;
    } probe_t;

    localparam int unsigned SECTOR_Q64 = 3840;
    localparam int unsigned SAT_FULL   = 65280;
    localparam int unsigned RANDOM_REQ = 750;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;

    hsv_t hsv_pending[$];
    hsv_t hsv_head;
    int   errors = 0;
    bit   calm   = 1'b0;

    // red, green, blue extremes, ties for the maximum, wrap of the red sector
    probe_t probes [23] = '{
        '{32'h0000_0000, 1'b1, '{15'd0,     16'd0,     8'd0}},
        '{32'hFFFF_FFFF, 1'b1, '{15'd0,     16'd0,     8'd255}},
        '{32'hFF00_0000, 1'b1, '{15'd0,     16'd0,     8'd0}},
        '{32'h00FF_0000, 1'b1, '{15'd0,     16'd65280, 8'd255}},
        '{32'h0000_FF00, 1'b1, '{15'd7680,  16'd65280, 8'd255}},
        '{32'h0000_00FF, 1'b1, '{15'd15360, 16'd65280, 8'd255}},
        '{32'h80FF_0000, 1'b1, '{15'd0,     16'd65280, 8'd255}},
        '{32'h0080_8080, 1'b1, '{15'd0,     16'd0,     8'd128}},
        '{32'h00FF_FF00, 1'b0, '0},
        '{32'h0000_FFFF, 1'b0, '0},
        '{32'h00FF_00FF, 1'b0, '0},
        '{32'h00FF_0001, 1'b0, '0},
        '{32'h00FE_00FF, 1'b0, '0},
        '{32'h0001_0000, 1'b0, '0},
        '{32'h0000_0100, 1'b0, '0},
        '{32'h0000_0001, 1'b0, '0},
        '{32'h00FF_FEFF, 1'b0, '0},
        '{32'h00FE_FFFF, 1'b0, '0},
        '{32'h00FF_FFFE, 1'b0, '0},
        '{32'h5A12_3456, 1'b0, '0},
        '{32'h00FF_7F00, 1'b0, '0},
        '{32'h0001_0001, 1'b0, '0},
        '{32'hA501_FF01, 1'b0, '0}
    };

    rgb_to_hsv_converter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic hsv_t hsv_of_pixel(input logic [IN_W-1:0] px);
        int unsigned red, green, blue, top, bottom, span, base, pos, neg, num;
        hsv_t res;
        red    = 32'(px[23:16]);
        green  = 32'(px[15:8]);
        blue   = 32'(px[7:0]);
        top    = red;
        bottom = red;
        if (green > top) top = green;
        if (blue > top) top = blue;
        if (green < bottom) bottom = green;
        if (blue < bottom) bottom = blue;
        span = top - bottom;
        res = '0;
        res.value = top[CHAN_W-1:0];
        if (span != 0) begin
            res.sat = SAT_W'(SAT_FULL * span / top);
            // red wins ties, then green
            if (red == top) begin
                base = 32'(HUE_RED_BASE); pos = green; neg = blue;
            end else if (green == top) begin
                base = 32'(HUE_GREEN_BASE); pos = blue; neg = red;
            end else begin
                base = 32'(HUE_BLUE_BASE); pos = red; neg = green;
            end
            if (pos >= neg) begin
                num = base * span + SECTOR_Q64 * (pos - neg);
            end else begin
                if (base == 32'(HUE_RED_BASE)) base = 32'(HUE_FULL_TURN);
                num = base * span - SECTOR_Q64 * (neg - pos);
            end
            res.hue = HUE_W'(num / span);
        end
        return res;
    endfunction

    function automatic logic [IN_W-1:0] random_pixel();
        logic [7:0] chan [3];
        logic [7:0] c;
        int unsigned pick;
        for (int i = 0; i < 3; i++) chan[i] = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            5: begin
                c = chan[0];
                chan[1] = c;
                chan[2] = c;
            end
            6: begin
                // two channels share the maximum or the minimum
                pick = $urandom_range(0, 2);
                chan[(pick + 1) % 3] = chan[pick];
            end
            7: begin
                for (int i = 0; i < 3; i++) chan[i] = 8'($urandom_range(0, 3));
            end
            8: begin
                c = 8'($urandom_range(2, 253));
                for (int i = 0; i < 3; i++) chan[i] = 8'(c + $urandom_range(0, 4) - 2);
            end
            9: begin
                for (int i = 0; i < 3; i++)
                    case ($urandom_range(0, 2))
                        0: chan[i] = 8'd0;
                        1: chan[i] = 8'd255;
                        default: ;
                    endcase
            end
            default: ;
        endcase
        return {8'($urandom), chan[0], chan[1], chan[2]};
    endfunction

    task automatic send_pixel(input logic [IN_W-1:0] px, input bit typed, input hsv_t typed_res);
        while (!calm && $urandom_range(0, 99) < 20) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        hsv_pending.push_back(typed ? typed_res : hsv_of_pixel(px));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (hsv_pending.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 20);
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (hsv_pending.size() == 0) begin
                $error("unexpected result, tdata %h", m_axis_tdata);
                errors++;
            end else begin
                hsv_head = hsv_pending.pop_front();
                if (m_axis_tdata[HUE_W-1:0] !== hsv_head.hue) begin
                    $error("hue_fixed: expected %0d, got %0d",
                           hsv_head.hue, m_axis_tdata[HUE_W-1:0]);
                    errors++;
                end
                if (m_axis_tdata[HUE_W +: SAT_W] !== hsv_head.sat) begin
                    $error("saturation_fixed: expected %0d, got %0d",
                           hsv_head.sat, m_axis_tdata[HUE_W +: SAT_W]);
                    errors++;
                end
                if (m_axis_tdata[HUE_W+SAT_W +: CHAN_W] !== hsv_head.value) begin
                    $error("value_level: expected %0d, got %0d",
                           hsv_head.value, m_axis_tdata[HUE_W+SAT_W +: CHAN_W]);
                    errors++;
                end
                if (m_axis_tdata[OUT_W-1] !== 1'b0) begin
                    $error("padding: expected 0, got %b", m_axis_tdata[OUT_W-1]);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (probes[i]) send_pixel(probes[i].pixel, probes[i].typed, probes[i].result);
        drain_results();

        for (int n = 0; n < RANDOM_REQ; n++) begin
            // a quiet stretch with no idling on either side
            calm = (n >= 300 && n < 420);
            if (n == 500) drain_results();
            send_pixel(random_pixel(), 1'b0, '0);
        end
        calm = 1'b0;

        drain_results();
        repeat (40) @(posedge aclk);
        if (errors == 0 && hsv_pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/rgbhsv_pkg.sv
rtl/core/rgbhsv_front.sv
rtl/core/rgbhsv_cell.sv
rtl/core/rgbhsv_back.sv
rtl/core/rgb_to_hsv_converter.sv
verif/tb_top.sv
